[rtl/core/assert_macros.svh]
// Assertion macros shared by the bicubic interpolator RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

[rtl/core/bcr_pkg.sv]
// Shared types and constants for the Catmull-Rom bicubic interpolator.
// No dependencies; imported by every module of the block.
package bcr_pkg;

    // Multiplier digit width of the cubic engine (bits of t per cycle)
    localparam int DIG_BITS = 8;

    // Decoupling queue depth (power of two)
    localparam int QUEUE_DEPTH = 2;

    // Patch row index; the last row triggers the y pass
    typedef logic [1:0] t_row_idx;
    localparam t_row_idx FIRST_ROW = 2'd0;
    localparam t_row_idx LAST_ROW  = 2'd3;

    // Horner step codes of the cubic engine
    typedef logic [1:0] t_step;
    localparam t_step STEP_C = 2'd0;
    localparam t_step STEP_B = 2'd1;
    localparam t_step STEP_A = 2'd2;

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_MUL  = 3'b010,
        C_ADD  = 3'b100
    } t_cub_state;

    typedef enum logic [4:0] {
        B_IDLE   = 5'b00001,
        B_ROW    = 5'b00010,
        B_YSTART = 5'b00100,
        B_COL    = 5'b01000,
        B_EMIT   = 5'b10000
    } t_back_state;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic busy;
        logic done;
    } t_cub_status;

endpackage

[rtl/core/bcr_front.sv]
// Front end: accepts patch rows, tags each with its row index, packs a queue entry.
// Depends on bcr_pkg.
module bcr_front
    import bcr_pkg::*;
#(
    parameter int SAMPLE_W = 16,
    parameter int FRAC_W   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_W-1:0]    i_sample_a,
    input  logic signed [SAMPLE_W-1:0]    i_sample_b,
    input  logic signed [SAMPLE_W-1:0]    i_sample_c,
    input  logic signed [SAMPLE_W-1:0]    i_sample_d,
    input  logic        [FRAC_W-1:0]      i_frac_x,
    input  logic        [FRAC_W-1:0]      i_frac_y,
    input  t_q_status                     i_q_status,
    output logic                          o_push,
    output logic [4*SAMPLE_W+2*FRAC_W+1:0] o_entry
);

    t_row_idx r_row;
    t_row_idx n_row;
    logic     [FRAC_W-1:0] w_frac_y;

    // Accept whenever the queue has room
    assign o_ready = !i_q_status.full;
    assign o_push  = i_valid && o_ready;

    // Row index of the next beat
    always_comb begin
        n_row = r_row;
        if (o_push) begin
            n_row = (r_row == LAST_ROW) ? FIRST_ROW : t_row_idx'(r_row + 2'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= FIRST_ROW;
        end else begin
            r_row <= n_row;
        end
    end

    // y fraction only matters on the last row; zero it elsewhere
    assign w_frac_y = (r_row == LAST_ROW) ? i_frac_y : '0;

    assign o_entry = {r_row, i_sample_a, i_sample_b, i_sample_c, i_sample_d,
                      i_frac_x, w_frac_y};

endmodule

[rtl/core/bcr_queue.sv]
// Short register queue between front and back ends.
// Depends on bcr_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bcr_queue
    import bcr_pkg::*;
#(
    parameter int WIDTH = 98
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_q_status        o_status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_status.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_data         = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = CNT_W'(r_count + 1'b1);
        end else if (!i_push && i_pop) begin
            n_count = CNT_W'(r_count - 1'b1);
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= PTR_W'(r_wr + 1'b1);
            end
            if (i_pop) begin
                r_rd <= PTR_W'(r_rd + 1'b1);
            end
            r_count <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `ASSERT_NEVER(a_q_overfill, i_clk, i_rst_n, r_count > CNT_W'(QUEUE_DEPTH), "queue overfilled")

endmodule

[rtl/core/bcr_cubic.sv]
// Catmull-Rom cubic engine: Horner evaluation with a digit-serial multiplier.
// Depends on bcr_pkg.
module bcr_cubic
    import bcr_pkg::*;
#(
    parameter int IN_W   = 18,
    parameter int FRAC_W = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [IN_W-1:0]   i_p0,
    input  logic signed [IN_W-1:0]   i_p1,
    input  logic signed [IN_W-1:0]   i_p2,
    input  logic signed [IN_W-1:0]   i_p3,
    input  logic        [FRAC_W-1:0] i_t,
    output t_cub_status              o_status,
    output logic signed [IN_W+5:0]   o_result
);

    localparam int COEF_W    = IN_W + 4;
    localparam int ACC_W     = COEF_W + 3 * FRAC_W + 3;
    localparam int RES_W     = COEF_W + 2;
    localparam int NDIG      = (FRAC_W + DIG_BITS - 1) / DIG_BITS;
    localparam int TP_W      = NDIG * DIG_BITS;
    localparam int DIG_CNT_W = (NDIG > 1) ? $clog2(NDIG) : 1;

    t_cub_state                 r_state;
    t_cub_state                 n_state;
    logic                       r_done;
    logic                       n_done;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [ACC_W-1:0]    n_acc;
    logic signed [ACC_W-1:0]    r_prod;
    logic signed [ACC_W-1:0]    n_prod;
    logic        [TP_W-1:0]     r_t;
    logic        [TP_W-1:0]     n_t;
    logic [DIG_CNT_W-1:0]       r_dig;
    logic [DIG_CNT_W-1:0]       n_dig;
    t_step                      r_step;
    t_step                      n_step;
    logic signed [COEF_W-1:0]   r_ca, r_cb, r_cc;

    logic signed [COEF_W-1:0]   w_p0, w_p1, w_p2, w_p3;
    logic signed [COEF_W-1:0]   w_a, w_b, w_c, w_d;
    logic        [DIG_BITS-1:0] w_digit;
    logic signed [ACC_W+DIG_BITS:0] w_mul;
    logic signed [ACC_W-1:0]    w_addend;

    // Polynomial coefficients of the start operands (times two)
    assign w_p0 = COEF_W'(i_p0);
    assign w_p1 = COEF_W'(i_p1);
    assign w_p2 = COEF_W'(i_p2);
    assign w_p3 = COEF_W'(i_p3);
    assign w_a  = w_p1 <<< 1;
    assign w_b  = w_p2 - w_p0;
    assign w_c  = (w_p0 <<< 1) - ((w_p1 <<< 2) + w_p1) + (w_p2 <<< 2) - w_p3;
    assign w_d  = (w_p1 - w_p2) + ((w_p1 - w_p2) <<< 1) + w_p3 - w_p0;

    // One digit of t per cycle, most significant first
    assign w_digit = r_t[TP_W-1 -: DIG_BITS];
    assign w_mul   = r_acc * $signed({1'b0, w_digit});

    // Coefficient at its weight after each Horner step; A also adds the half
    always_comb begin
        unique case (r_step)
            STEP_C:  w_addend = ACC_W'(r_cc) <<< FRAC_W;
            STEP_B:  w_addend = ACC_W'(r_cb) <<< (2 * FRAC_W);
            default: w_addend = (ACC_W'(r_ca) <<< (3 * FRAC_W))
                              + (ACC_W'(1) <<< (3 * FRAC_W));
        endcase
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_acc   = r_acc;
        n_prod  = r_prod;
        n_t     = r_t;
        n_dig   = r_dig;
        n_step  = r_step;
        unique case (r_state)
            C_IDLE: begin
                if (i_start) begin
                    n_acc   = ACC_W'(w_d);
                    n_prod  = '0;
                    n_t     = TP_W'(i_t);
                    n_dig   = '0;
                    n_step  = STEP_C;
                    n_state = C_MUL;
                end
            end
            C_MUL: begin
                n_prod = (r_prod <<< DIG_BITS) + ACC_W'(w_mul);
                n_t    = (r_t << DIG_BITS) | (r_t >> (TP_W - DIG_BITS));
                if (r_dig == DIG_CNT_W'(NDIG - 1)) begin
                    n_dig   = '0;
                    n_state = C_ADD;
                end else begin
                    n_dig = DIG_CNT_W'(r_dig + 1'b1);
                end
            end
            C_ADD: begin
                n_acc  = r_prod + w_addend;
                n_prod = '0;
                if (r_step == STEP_A) begin
                    n_done  = 1'b1;
                    n_state = C_IDLE;
                end else begin
                    n_step  = t_step'(r_step + 1'b1);
                    n_state = C_MUL;
                end
            end
            default: n_state = C_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_prod <= n_prod;
        r_t    <= n_t;
        r_dig  <= n_dig;
        r_step <= n_step;
        if (r_state == C_IDLE && i_start) begin
            r_ca <= w_a;
            r_cb <= w_b;
            r_cc <= w_c;
        end
    end

    // Halve and round: ties toward plus infinity via the added half
    assign o_result      = RES_W'(r_acc >>> (3 * FRAC_W + 1));
    assign o_status.busy = (r_state != C_IDLE);
    assign o_status.done = r_done;

endmodule

[rtl/core/bcr_back.sv]
// Back end: runs the row cubic, keeps row results, runs the column cubic, holds output.
// Depends on bcr_pkg, bcr_cubic and assert_macros.svh.
`include "assert_macros.svh"
module bcr_back
    import bcr_pkg::*;
#(
    parameter int SAMPLE_W = 16,
    parameter int FRAC_W   = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_q_status                      i_q_status,
    input  logic [4*SAMPLE_W+2*FRAC_W+1:0] i_entry,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [SAMPLE_W-1:0]     o_value
);

    localparam int ROW_W = SAMPLE_W + 2;
    localparam int RES_W = ROW_W + 6;
    localparam int SMP_LO = 2 * FRAC_W;
    localparam int IDX_LO = 4 * SAMPLE_W + 2 * FRAC_W;

    localparam logic signed [RES_W-1:0] ROW_MAX =
        {{(RES_W - ROW_W + 1){1'b0}}, {(ROW_W - 1){1'b1}}};
    localparam logic signed [RES_W-1:0] ROW_MIN = ~ROW_MAX;
    localparam logic signed [RES_W-1:0] OUT_MAX =
        {{(RES_W - SAMPLE_W + 1){1'b0}}, {(SAMPLE_W - 1){1'b1}}};
    localparam logic signed [RES_W-1:0] OUT_MIN = ~OUT_MAX;

    t_back_state                r_state;
    t_back_state                n_state;
    t_row_idx                   r_idx;
    logic        [FRAC_W-1:0]   r_ty;
    logic signed [ROW_W-1:0]    r_part [3];
    logic signed [ROW_W-1:0]    r_row3;
    logic                       r_out_valid;
    logic                       n_out_valid;
    logic signed [SAMPLE_W-1:0] r_value;

    t_row_idx                   w_e_idx;
    logic signed [SAMPLE_W-1:0] w_e_a, w_e_b, w_e_c, w_e_d;
    logic        [FRAC_W-1:0]   w_e_fx, w_e_fy;
    logic                       w_start;
    logic                       w_load_out;
    logic signed [ROW_W-1:0]    w_p0, w_p1, w_p2, w_p3;
    logic        [FRAC_W-1:0]   w_t;
    t_cub_status                w_cub;
    logic signed [RES_W-1:0]    w_res;
    logic signed [ROW_W-1:0]    w_row_sat;
    logic signed [SAMPLE_W-1:0] w_out_sat;

    // Entry fields
    assign w_e_idx = i_entry[IDX_LO +: 2];
    assign w_e_a   = i_entry[SMP_LO + 3 * SAMPLE_W +: SAMPLE_W];
    assign w_e_b   = i_entry[SMP_LO + 2 * SAMPLE_W +: SAMPLE_W];
    assign w_e_c   = i_entry[SMP_LO + SAMPLE_W +: SAMPLE_W];
    assign w_e_d   = i_entry[SMP_LO +: SAMPLE_W];
    assign w_e_fx  = i_entry[FRAC_W +: FRAC_W];
    assign w_e_fy  = i_entry[FRAC_W-1:0];

    // Cubic operands: queue entry for the row pass, stored rows for the column pass
    always_comb begin
        if (r_state == B_YSTART) begin
            w_p0 = r_part[0];
            w_p1 = r_part[1];
            w_p2 = r_part[2];
            w_p3 = r_row3;
            w_t  = r_ty;
        end else begin
            w_p0 = ROW_W'(w_e_a);
            w_p1 = ROW_W'(w_e_b);
            w_p2 = ROW_W'(w_e_c);
            w_p3 = ROW_W'(w_e_d);
            w_t  = w_e_fx;
        end
    end

    bcr_cubic #(
        .IN_W   (ROW_W),
        .FRAC_W (FRAC_W)
    ) u_cubic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_p0     (w_p0),
        .i_p1     (w_p1),
        .i_p2     (w_p2),
        .i_p3     (w_p3),
        .i_t      (w_t),
        .o_status (w_cub),
        .o_result (w_res)
    );

    // Saturation of row and final results
    assign w_row_sat = (w_res > ROW_MAX) ? ROW_MAX[ROW_W-1:0] :
                       (w_res < ROW_MIN) ? ROW_MIN[ROW_W-1:0] : w_res[ROW_W-1:0];
    assign w_out_sat = (w_res > OUT_MAX) ? OUT_MAX[SAMPLE_W-1:0] :
                       (w_res < OUT_MIN) ? OUT_MIN[SAMPLE_W-1:0] : w_res[SAMPLE_W-1:0];

    // Back-end sequencer
    always_comb begin
        n_state    = r_state;
        w_start    = 1'b0;
        o_pop      = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_status.empty) begin
                    w_start = 1'b1;
                    o_pop   = 1'b1;
                    n_state = B_ROW;
                end
            end
            B_ROW: begin
                if (w_cub.done) begin
                    n_state = (r_idx == LAST_ROW) ? B_YSTART : B_IDLE;
                end
            end
            B_YSTART: begin
                w_start = 1'b1;
                n_state = B_COL;
            end
            B_COL: begin
                if (w_cub.done) begin
                    n_state = B_EMIT;
                end
            end
            B_EMIT: begin
                if (!r_out_valid || i_ready) begin
                    w_load_out = 1'b1;
                    n_state    = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    // Output slot
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_idx <= w_e_idx;
            r_ty  <= w_e_fy;
        end
        if (r_state == B_ROW && w_cub.done) begin
            if (r_idx == LAST_ROW) begin
                r_row3 <= w_row_sat;
            end else begin
                r_part[r_idx] <= w_row_sat;
            end
        end
        if (w_load_out) begin
            r_value <= w_out_sat;
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_value;

    `ASSERT_CLK(a_start_idle, i_clk, i_rst_n, w_start |-> !w_cub.busy, "cubic started while busy")
    `ASSERT_CLK(a_out_from_emit, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == B_EMIT), "output loaded outside emit")

endmodule

[rtl/core/bicubic_catmull_rom_interpolator.sv]
// Top level of the Catmull-Rom bicubic interpolator (4x4 patch, one row per beat).
// Depends on bcr_pkg, bcr_front, bcr_queue and bcr_back.
//
//   channel  direction  handshake          payload
//   -------  ---------  -----------------  -----------------------------------------
//   row in   input      i_valid / o_ready  i_sample_a..d, i_frac_x, i_frac_y
//   value    output     o_valid / i_ready  o_value
//
// A row beat holds the back end for a dispatch step, the Horner steps of the shared
// cubic engine and a completion step; every fourth beat adds a column pass and an output
// load. The cubic engine multiplies by the fraction in 8-bit digits, most significant first.
// A two-beat queue lets rows be taken while the engine works; the output register
// frees the engine while a value waits. Reset (i_rst_n low, synchronous) returns to row 0.
module bicubic_catmull_rom_interpolator
    import bcr_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_a,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_b,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_c,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_d,
    input  logic        [FRAC_BITS-1:0]   i_frac_x,
    input  logic        [FRAC_BITS-1:0]   i_frac_y,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_value
);

    localparam int ENTRY_W = 4 * SAMPLE_BITS + 2 * FRAC_BITS + 2;

    logic               w_push;
    logic               w_pop;
    logic [ENTRY_W-1:0] w_in_entry;
    logic [ENTRY_W-1:0] w_out_entry;
    t_q_status          w_q_status;

    bcr_front #(
        .SAMPLE_W (SAMPLE_BITS),
        .FRAC_W   (FRAC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_sample_a (i_sample_a),
        .i_sample_b (i_sample_b),
        .i_sample_c (i_sample_c),
        .i_sample_d (i_sample_d),
        .i_frac_x   (i_frac_x),
        .i_frac_y   (i_frac_y),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_entry    (w_in_entry)
    );

    bcr_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_in_entry),
        .i_pop    (w_pop),
        .o_data   (w_out_entry),
        .o_status (w_q_status)
    );

    bcr_back #(
        .SAMPLE_W (SAMPLE_BITS),
        .FRAC_W   (FRAC_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (w_q_status),
        .i_entry    (w_out_entry),
        .o_pop      (w_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_value    (o_value)
    );

endmodule

[verif/bcr_value_checker.sv]
// Scoreboard for the Catmull-Rom bicubic interpolator: watches the row and value channels.
// Predicts each patch value from the accepted row beats; uses bcr_pkg for row indexes.
`timescale 1ns / 1ps

module bcr_value_checker
    import bcr_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_row_valid,
    input  logic                          i_row_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_a,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_b,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_c,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_d,
    input  logic        [FRAC_BITS-1:0]   i_frac_x,
    input  logic        [FRAC_BITS-1:0]   i_frac_y,
    input  logic                          i_value_valid,
    input  logic                          i_value_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_value,
    output int                            o_fail_cnt,
    output int                            o_pending
);

    localparam int ROW_BITS = SAMPLE_BITS + 2;

    logic signed [SAMPLE_BITS-1:0] value_q[$];
    longint                        row_sum[3];
    t_row_idx                      row_pos;
    longint                        row_val;
    longint                        col_val;
    logic signed [SAMPLE_BITS-1:0] want;
    int                            fail_total;

    // Exact Catmull-Rom cubic (tension 0.5), Horner form in fixed point,
    // rounded to nearest with ties toward +inf
    function automatic longint catmull_eval(input longint p0, input longint p1,
                                            input longint p2, input longint p3,
                                            input logic [FRAC_BITS-1:0] t);
        logic signed [127:0] acc;
        logic signed [127:0] tt;
        logic signed [127:0] ka;
        logic signed [127:0] kb;
        logic signed [127:0] kc;
        ka  = 2 * p1;
        kb  = p2 - p0;
        kc  = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        acc = -p0 + 3 * p1 - 3 * p2 + p3;
        tt  = $signed({{(128-FRAC_BITS){1'b0}}, t});
        acc = acc * tt + (kc <<< FRAC_BITS);
        acc = acc * tt + (kb <<< (2 * FRAC_BITS));
        acc = acc * tt + (ka <<< (3 * FRAC_BITS));
        // +0.5 in units of the final lsb, then drop the fraction and the 0.5 factor
        acc = acc + (128'sd1 <<< (3 * FRAC_BITS));
        acc = acc >>> (3 * FRAC_BITS + 1);
        return $signed(acc[63:0]);
    endfunction

    function automatic longint clamp_to(input longint v, input int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    initial begin
        fail_total = 0;
        row_pos    = FIRST_ROW;
        o_fail_cnt = 0;
        o_pending  = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            row_pos = FIRST_ROW;
        end else begin
            // value beat: compare against the oldest prediction
            if (i_value_valid && i_value_ready) begin
                if (value_q.size() == 0) begin
                    if (fail_total < 10)
                        $display("%0t: unexpected value beat, got %0d", $realtime, i_value);
                    fail_total++;
                end else begin
                    want = value_q.pop_front();
                    if (want !== i_value) begin
                        if (fail_total < 10)
                            $display("%0t: value mismatch, expected %0d got %0d",
                                     $realtime, want, i_value);
                        fail_total++;
                    end
                end
            end
            // row beat: x pass on the row, y pass on the last row of the patch
            if (i_row_valid && i_row_ready) begin
                row_val = clamp_to(catmull_eval(i_sample_a, i_sample_b, i_sample_c,
                                                i_sample_d, i_frac_x), ROW_BITS);
                if (row_pos == LAST_ROW) begin
                    col_val = clamp_to(catmull_eval(row_sum[0], row_sum[1], row_sum[2],
                                                    row_val, i_frac_y), SAMPLE_BITS);
                    value_q.push_back(col_val[SAMPLE_BITS-1:0]);
                    row_pos = FIRST_ROW;
                end else begin
                    row_sum[row_pos] = row_val;
                    row_pos = row_pos + 1'b1;
                end
            end
        end
        o_fail_cnt <= fail_total;
        o_pending  <= value_q.size();
    end

endmodule

[verif/testbench.sv]
// Top of the bicubic interpolator testbench: clock, reset, row stimulus and value-side stalls.
// Depends on bicubic_catmull_rom_interpolator and bcr_value_checker.
`timescale 1ns / 1ps

module testbench;

    localparam int SB = 16;
    localparam int FB = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 60;
    localparam int RANDOM_PATCHES = 125;

    localparam logic [SB-1:0] S_MAX  = {1'b0, {(SB-1){1'b1}}};
    localparam logic [SB-1:0] S_MIN  = {1'b1, {(SB-1){1'b0}}};
    localparam logic [FB-1:0] F_ONES = {FB{1'b1}};
    localparam logic [FB-1:0] F_HALF = {1'b1, {(FB-1){1'b0}}};

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_ready;
    logic [SB-1:0] i_sample_a;
    logic [SB-1:0] i_sample_b;
    logic [SB-1:0] i_sample_c;
    logic [SB-1:0] i_sample_d;
    logic [FB-1:0] i_frac_x;
    logic [FB-1:0] i_frac_y;
    logic          o_valid;
    logic          i_ready;
    logic [SB-1:0] o_value;

    int fail_cnt;
    int pend_cnt;
    int cycle_cnt;
    int stall_left;
    bit idle_on;

    bicubic_catmull_rom_interpolator #(
        .SAMPLE_BITS(SB),
        .FRAC_BITS  (FB)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_sample_a(i_sample_a),
        .i_sample_b(i_sample_b),
        .i_sample_c(i_sample_c),
        .i_sample_d(i_sample_d),
        .i_frac_x  (i_frac_x),
        .i_frac_y  (i_frac_y),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_value   (o_value)
    );

    bcr_value_checker #(
        .SAMPLE_BITS(SB),
        .FRAC_BITS  (FB)
    ) checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_row_valid  (i_valid),
        .i_row_ready  (o_ready),
        .i_sample_a   (i_sample_a),
        .i_sample_b   (i_sample_b),
        .i_sample_c   (i_sample_c),
        .i_sample_d   (i_sample_d),
        .i_frac_x     (i_frac_x),
        .i_frac_y     (i_frac_y),
        .i_value_valid(o_valid),
        .i_value_ready(i_ready),
        .i_value      (o_value),
        .o_fail_cnt   (fail_cnt),
        .o_pending    (pend_cnt)
    );

    // 8 ns clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // watchdog
    initial cycle_cnt = 0;
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // value side: ready drops in bursts of random length while idling is on
    initial stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 5);
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Mostly random, with a fair share of the extremes
    function automatic logic [SB-1:0] pick_sample();
        case ($urandom_range(0, 11))
            0:       return S_MIN;
            1:       return S_MAX;
            2:       return '0;
            3:       return '1;
            default: return SB'($urandom);
        endcase
    endfunction

    function automatic logic [FB-1:0] pick_frac();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return F_ONES;
            2:       return F_HALF;
            default: return FB'($urandom);
        endcase
    endfunction

    // One row beat; the sender may go idle for a burst first
    task automatic send_row(input logic [SB-1:0] a, input logic [SB-1:0] b,
                            input logic [SB-1:0] c, input logic [SB-1:0] d,
                            input logic [FB-1:0] fx, input logic [FB-1:0] fy);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_sample_a <= a;
        i_sample_b <= b;
        i_sample_c <= c;
        i_sample_d <= d;
        i_frac_x   <= fx;
        i_frac_y   <= fy;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Stop sending until every predicted value has come out
    task automatic hold_until_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pend_cnt != 0);
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_ready    <= 1'b1;
        i_sample_a <= '0;
        i_sample_b <= '0;
        i_sample_c <= '0;
        i_sample_d <= '0;
        i_frac_x   <= '0;
        i_frac_y   <= '0;
        idle_on     = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // flat patches at both rails, fractions at both ends
        repeat (4) send_row(S_MAX, S_MAX, S_MAX, S_MAX, '0, '0);
        repeat (4) send_row(S_MIN, S_MIN, S_MIN, S_MIN, F_ONES, F_ONES);
        // overshoot in x and in y: final value clips high
        send_row(S_MAX, S_MIN, S_MIN, S_MAX, F_HALF, pick_frac());
        send_row(S_MIN, S_MAX, S_MAX, S_MIN, F_HALF, pick_frac());
        send_row(S_MIN, S_MAX, S_MAX, S_MIN, F_HALF, pick_frac());
        send_row(S_MAX, S_MIN, S_MIN, S_MAX, F_HALF, F_HALF);
        // mirror image: final value clips low
        send_row(S_MIN, S_MAX, S_MAX, S_MIN, F_HALF, pick_frac());
        send_row(S_MAX, S_MIN, S_MIN, S_MAX, F_HALF, pick_frac());
        send_row(S_MAX, S_MIN, S_MIN, S_MAX, F_HALF, pick_frac());
        send_row(S_MIN, S_MAX, S_MAX, S_MIN, F_HALF, F_HALF);
        // ramp with fractions one step in from the ends
        repeat (4) send_row(S_MIN, -16'sd10923, 16'sd10922, S_MAX, FB'(1), F_ONES - 1'b1);
        // checkerboard of rails with random fractions
        for (int r = 0; r < 4; r++) begin
            if (r[0])
                send_row(S_MIN, S_MAX, S_MIN, S_MAX, pick_frac(), pick_frac());
            else
                send_row(S_MAX, S_MIN, S_MAX, S_MIN, pick_frac(), pick_frac());
        end
        hold_until_drained();

        // random patches; the tail runs without idling on either side
        for (int p = 0; p < RANDOM_PATCHES; p++) begin
            if (p == RANDOM_PATCHES / 2)
                hold_until_drained();
            if (p == RANDOM_PATCHES - 25)
                idle_on = 1'b0;
            for (int r = 0; r < 4; r++)
                send_row(pick_sample(), pick_sample(), pick_sample(), pick_sample(),
                         pick_frac(), pick_frac());
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0 && pend_cnt == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
